[hdl/morse_symbol_pair_decoder_top_defines.svh]
// Assertion macros shared by the Morse symbol-pair decoder RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef MORSE_SYMBOL_PAIR_DECODER_TOP_DEFINES_SVH
`define MORSE_SYMBOL_PAIR_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MSP_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
`define MSP_ASSERT_IMPLY(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`else
`define MSP_ASSERT_ALWAYS(name, expr, msg)
`define MSP_ASSERT_IMPLY(name, cond, expr, msg)
`endif

`endif

[hdl/msp_pkg.sv]
// Shared types, constants and the character ROM of the Morse symbol-pair decoder.
// No dependencies.
package msp_pkg;

    localparam int MAX_SYMBOLS = 7;
    localparam int CODE_W      = 14;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 2);
    localparam int CHAR_W      = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;
    localparam logic [CHAR_W-1:0] NULL_CHAR  = 7'h00;

    typedef enum logic [1:0] {
        SYM_END  = 2'b00,
        SYM_DASH = 2'b01,
        SYM_DOT  = 2'b10,
        SYM_WORD = 2'b11
    } sym_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_of_run;
    } out_t;

    // one end-of-character event handed from front to back
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              code_ok;   // count in 1..MAX_SYMBOLS
        logic              space;     // word end: space follows
        logic              last;      // final event of its byte
    } evt_t;

    function automatic logic [CHAR_W-1:0] rom_lookup(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            14'd9:     ch = 7'h41;
            14'd106:   ch = 7'h42;
            14'd102:   ch = 7'h43;
            14'd26:    ch = 7'h44;
            14'd2:     ch = 7'h45;
            14'd166:   ch = 7'h46;
            14'd22:    ch = 7'h47;
            14'd170:   ch = 7'h48;
            14'd10:    ch = 7'h49;
            14'd149:   ch = 7'h4A;
            14'd25:    ch = 7'h4B;
            14'd154:   ch = 7'h4C;
            14'd5:     ch = 7'h4D;
            14'd6:     ch = 7'h4E;
            14'd21:    ch = 7'h4F;
            14'd150:   ch = 7'h50;
            14'd89:    ch = 7'h51;
            14'd38:    ch = 7'h52;
            14'd42:    ch = 7'h53;
            14'd1:     ch = 7'h54;
            14'd41:    ch = 7'h55;
            14'd169:   ch = 7'h56;
            14'd37:    ch = 7'h57;
            14'd105:   ch = 7'h58;
            14'd101:   ch = 7'h59;
            14'd90:    ch = 7'h5A;
            14'd341:   ch = 7'h30;
            14'd597:   ch = 7'h31;
            14'd661:   ch = 7'h32;
            14'd677:   ch = 7'h33;
            14'd681:   ch = 7'h34;
            14'd682:   ch = 7'h35;
            14'd426:   ch = 7'h36;
            14'd362:   ch = 7'h37;
            14'd346:   ch = 7'h38;
            14'd342:   ch = 7'h39;
            14'd2390:  ch = 7'h27;
            14'd2406:  ch = 7'h40;
            14'd1386:  ch = 7'h3A;
            14'd1445:  ch = 7'h2C;
            14'd10857: ch = 7'h24;
            14'd425:   ch = 7'h3D;
            14'd1637:  ch = 7'h21;
            14'd2457:  ch = 7'h2E;
            14'd2650:  ch = 7'h3F;
            14'd2470:  ch = 7'h22;
            default:   ch = NULL_CHAR;
        endcase
        return ch;
    endfunction

endpackage

[hdl/morse_symbol_pair_decoder_top.sv]
// Path: a byte's results pass the byte register, the event queue and the output register.
// Throughput: one symbol per cycle while the queue has room; a new byte is taken as the
// last symbol retires. Results leave at one per cycle while out_ready is high.
// Reset: rst_n asynchronous, active low; clears pending code, queue and output valid.
// Depends on msp_pkg, msp_front, msp_fifo, msp_back.
module morse_symbol_pair_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  msp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output msp_pkg::out_t out_data
);

    // Front end: holds one byte transaction, steps its four symbols,
    // appends dots/dashes to the code and pushes an event per terminator.
    // It takes the next byte in the same cycle its last symbol retires.
    logic          push_valid, push_ready;
    msp_pkg::evt_t push_data;

    // Queue decouples the symbol walk from output backpressure.
    logic          pop_valid, pop_ready;
    msp_pkg::evt_t pop_data;

    msp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    msp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back end: ROM lookup into the output register; word ends produce
    // a second transaction carrying the space.
    msp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[hdl/msp_front.sv]
// Front end: accepts bytes, walks their four symbols, keeps the pending code
// and pushes end-of-character events. Depends on msp_pkg and the defines header.
`include "morse_symbol_pair_decoder_top_defines.svh"

module msp_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  msp_pkg::in_t in_data,
    output logic         push_valid,
    input  logic         push_ready,
    output msp_pkg::evt_t push_data
);

    logic [7:0]                   byte_reg;
    logic                         eos_reg;
    logic [1:0]                   idx_reg, idx_next;
    logic                         busy_reg, busy_next;
    logic [msp_pkg::CODE_W-1:0]   code_reg, code_next;
    logic [msp_pkg::CNT_W-1:0]    cnt_reg, cnt_next;

    msp_pkg::sym_t sym;
    logic          is_term;
    logic          later_term;
    logic          step_fire;
    logic          done;
    logic          accept;

    assign sym     = msp_pkg::sym_t'(byte_reg[{~idx_reg, 1'b0} +: 2]);
    assign is_term = (sym == msp_pkg::SYM_END) || (sym == msp_pkg::SYM_WORD);

    // any terminator further down the byte?
    always_comb
    begin
        later_term = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if ((2'(k) > idx_reg) &&
                ((msp_pkg::sym_t'(byte_reg[(3-k)*2 +: 2]) == msp_pkg::SYM_END) ||
                 (msp_pkg::sym_t'(byte_reg[(3-k)*2 +: 2]) == msp_pkg::SYM_WORD)))
            begin
                later_term = 1'b1;
            end
        end
    end

    assign step_fire = busy_reg && (!is_term || push_ready);
    assign done      = step_fire && (idx_reg == 2'd3);
    assign in_ready  = !busy_reg || done;
    assign accept    = in_valid && in_ready;

    assign push_valid        = busy_reg && is_term;
    assign push_data.code    = code_reg;
    assign push_data.code_ok = (cnt_reg != '0) &&
                               (cnt_reg <= msp_pkg::CNT_W'(msp_pkg::MAX_SYMBOLS));
    assign push_data.space   = (sym == msp_pkg::SYM_WORD);
    assign push_data.last    = !later_term;

    always_comb
    begin
        code_next = code_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (step_fire)
        begin
            idx_next = idx_reg + 2'd1;
            if (is_term)
            begin
                code_next = '0;
                cnt_next  = '0;
            end
            else if (cnt_reg <= msp_pkg::CNT_W'(msp_pkg::MAX_SYMBOLS))
            begin
                code_next = {code_reg[msp_pkg::CODE_W-3:0], sym};
                cnt_next  = cnt_reg + 1'b1;
            end
            if (done && eos_reg)
            begin
                code_next = '0;
                cnt_next  = '0;
            end
        end
        if (accept)
        begin
            idx_next  = 2'd0;
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            code_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            code_reg <= code_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= in_data.in_byte;
            eos_reg  <= in_data.end_of_stream;
        end
    end

    `MSP_ASSERT_ALWAYS(a_cnt_sat, (cnt_reg <= msp_pkg::CNT_W'(msp_pkg::MAX_SYMBOLS + 1)), "symbol count past saturation")
    `MSP_ASSERT_IMPLY(a_empty_code, (cnt_reg == '0), (code_reg == '0), "code bits set with empty count")
    `MSP_ASSERT_IMPLY(a_ready_mid_byte, (in_ready && busy_reg), (idx_reg == 2'd3 && step_fire), "ready while a byte is mid-walk")

endmodule

[hdl/msp_fifo.sv]
// Short event queue between front and back ends.
// Depends on msp_pkg.
module msp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  msp_pkg::evt_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output msp_pkg::evt_t pop_data
);

    localparam int PTR_W = $clog2(msp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(msp_pkg::QUEUE_DEPTH + 1);

    msp_pkg::evt_t    mem [msp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(msp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(msp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(msp_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/msp_back.sv]
// Back end: looks up characters, inserts word spaces, drives the output register.
// Depends on msp_pkg.
module msp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  msp_pkg::evt_t pop_data,
    output logic          out_valid,
    input  logic          out_ready,
    output msp_pkg::out_t out_data
);

    logic          out_valid_reg, out_valid_next;
    msp_pkg::out_t out_data_reg, out_data_next;
    logic          space_pend_reg, space_pend_next;
    logic          space_last_reg, space_last_next;
    logic          out_load;

    assign out_load  = !out_valid_reg || out_ready;
    assign pop_ready = out_load && !space_pend_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        space_pend_next = space_pend_reg;
        space_last_next = space_last_reg;
        if (out_load)
        begin
            if (space_pend_reg)
            begin
                out_valid_next            = 1'b1;
                out_data_next.out_char    = msp_pkg::SPACE_CHAR;
                out_data_next.last_of_run = space_last_reg;
                space_pend_next           = 1'b0;
            end
            else if (pop_valid)
            begin
                out_valid_next            = 1'b1;
                out_data_next.out_char    = pop_data.code_ok ?
                                            msp_pkg::rom_lookup(pop_data.code) :
                                            msp_pkg::NULL_CHAR;
                out_data_next.last_of_run = pop_data.last && !pop_data.space;
                space_pend_next           = pop_data.space;
                space_last_next           = pop_data.last;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            space_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            space_pend_reg <= space_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        space_last_reg <= space_last_next;
    end

endmodule
